// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the clocked assertions used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg
// Command codes, line limits and the segment word shared by the drawing engine.
// ----------------------------------------------------------------------------
package ifd_pkg;

   // Command codes of the input word. Code 7 is unused and draws nothing.
   typedef enum logic [2:0] {
      ACT_CLEAR = 3'd0,
      ACT_SET   = 3'd1,
      ACT_BYTE  = 3'd2,
      ACT_HLINE = 3'd3,
      ACT_VLINE = 3'd4,
      ACT_RECT  = 3'd5,
      ACT_READ  = 3'd6
   } action_type;

   // Longest horizontal and vertical line drawn by one line command.
   localparam logic [7:0] HLINE_LIMIT = 8'd127;
   localparam logic [7:0] VLINE_LIMIT = 8'd32;

   // One run of pixels along a row or a column, handed from front to back.
   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic       vert;         // step down the column instead of along the row
      logic [7:0] count;        // pixels in the run, zero for an empty run
      logic       use_pattern;  // take each pixel value from the pattern byte
      logic       value;        // pixel value when no pattern is used
      logic [7:0] pattern;
      logic       is_read;      // byte read instead of a pixel write
      logic       last;         // final run of its command, yields the result
   } seg_type;

endpackage

// ===== rtl/ifd_ram.sv =====
// ----------------------------------------------------------------------------
// ifd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ifd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read in the same cycle as a write to that address returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ifd_seg_fifo.sv =====
// ----------------------------------------------------------------------------
// ifd_seg_fifo
// Short queue of pixel runs between the command front end and the draw unit.
// ----------------------------------------------------------------------------
module ifd_seg_fifo import ifd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_data,
   output logic    full,
   input  logic    pop,
   output seg_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   seg_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates, with explicit wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage slots need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/ifd_front.sv =====
// ----------------------------------------------------------------------------
// ifd_front
// Command front end: takes a command word and splits it into pixel runs.
// ----------------------------------------------------------------------------
module ifd_front import ifd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       clear_busy,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_run_length,
   input  logic [7:0] req_pixel_bits,
   output logic       seg_push,
   output seg_type    seg_data,
   input  logic       seg_full
);

   typedef enum logic [1:0] {
      FR_IDLE = 2'b01,
      FR_EMIT = 2'b10
   } front_state_type;

   // A rectangle outline is four runs: left, right, top, bottom.
   localparam logic [1:0] RECT_LAST_SIDE = 2'd3;

   front_state_type state_ff, state_in;
   logic [1:0]      side_ff, side_in;
   logic [2:0]      action_ff;
   logic [7:0]      x_ff, y_ff, x_end_ff, y_end_ff, len_ff, bits_ff;
   logic [7:0]      rect_w, rect_h;
   logic            accept;

   function automatic logic [7:0] clip(input logic [7:0] value, input logic [7:0] limit);
      clip = (value < limit) ? value : limit;
   endfunction

   assign req_ready = (state_ff == FR_IDLE) && !clear_busy;
   assign accept    = req_valid && req_ready;
   assign seg_push  = (state_ff == FR_EMIT) && !seg_full;

   // Rectangle sizes wrap modulo 256.
   assign rect_w = x_end_ff - x_ff + 8'd1;
   assign rect_h = y_end_ff - y_ff;

   // Build the run for the held command and the current rectangle side.
   always_comb begin
      seg_data       = '0;
      seg_data.x     = x_ff;
      seg_data.y     = y_ff;
      seg_data.value = 1'b1;
      seg_data.last  = 1'b1;
      case (action_ff)
         ACT_CLEAR, ACT_SET: begin
            seg_data.count = 8'd1;
            seg_data.value = (action_ff == ACT_SET);
         end
         ACT_BYTE: begin
            seg_data.vert        = 1'b1;
            seg_data.count       = 8'd8;
            seg_data.use_pattern = 1'b1;
            seg_data.pattern     = bits_ff;
         end
         ACT_HLINE: begin
            seg_data.count = clip(len_ff, HLINE_LIMIT);
         end
         ACT_VLINE: begin
            seg_data.vert  = 1'b1;
            seg_data.count = clip(len_ff, VLINE_LIMIT);
         end
         ACT_RECT: begin
            seg_data.last = (side_ff == RECT_LAST_SIDE);
            case (side_ff)
               2'd0: begin
                  seg_data.vert  = 1'b1;
                  seg_data.count = clip(rect_h, VLINE_LIMIT);
               end
               2'd1: begin
                  seg_data.x     = x_end_ff;
                  seg_data.vert  = 1'b1;
                  seg_data.count = clip(rect_h, VLINE_LIMIT);
               end
               2'd2: begin
                  seg_data.count = clip(rect_w, HLINE_LIMIT);
               end
               default: begin
                  seg_data.y     = y_end_ff;
                  seg_data.count = clip(rect_w, HLINE_LIMIT);
               end
            endcase
         end
         ACT_READ: begin
            seg_data.count   = 8'd1;
            seg_data.is_read = 1'b1;
         end
         default: begin
            // Unused code: an empty run that only produces the result.
            seg_data.count = 8'd0;
         end
      endcase
   end

   // Sequencer: hold one command and push its runs one per cycle unless the queue is full.
   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               state_in = FR_EMIT;
               side_in  = 2'd0;
            end
         end
         FR_EMIT: begin
            if (seg_push) begin
               if (seg_data.last) begin
                  state_in = FR_IDLE;
               end else begin
                  side_in = side_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         side_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

   // Command word registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         x_ff      <= req_x;
         y_ff      <= req_y;
         x_end_ff  <= req_x_end;
         y_end_ff  <= req_y_end;
         len_ff    <= req_run_length;
         bits_ff   <= req_pixel_bits;
      end
   end

endmodule

// ===== rtl/ifd_back.sv =====
// ----------------------------------------------------------------------------
// ifd_back
// Draw unit: walks pixel runs, read-modify-writes the frame store, answers.
// ----------------------------------------------------------------------------
module ifd_back import ifd_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   output logic       clear_busy,
   input  logic       seg_empty,
   input  seg_type    seg_data,
   output logic       seg_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_raw_byte,
   output logic [7:0] rsp_ordered_byte,
   output logic [8:0] rsp_byte_index,
   output logic       rsp_in_range
);

   localparam int PAGES      = (ROWS + 7) / 8;
   localparam int STORE_SIZE = COLUMNS * PAGES;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int LIN_W      = 14;

   // Current run and pixel counter.
   seg_type           seg_ff, seg_in;
   logic              seg_valid_ff, seg_valid_in;
   logic [7:0]        step_ff, step_in;

   // Clearing pass after reset.
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Pixel being issued.
   logic [7:0]        px, py;
   logic              op_inside, op_final, op_last, op_val, issue;
   logic [LIN_W-1:0]  lin;
   logic [ADDR_W-1:0] op_addr;
   logic [2:0]        op_bit;

   // Write stage.
   logic              b_valid_ff, b_write_ff, b_val_ff, b_read_ff;
   logic              b_inside_ff, b_last_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [2:0]        b_bit_ff;
   logic [8:0]        b_index_ff;

   // Bypass of the write that landed on the previous edge.
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;

   logic [7:0]        ram_rd, base, mask, merged;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [7:0]        ram_wd;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_raw_ff, rsp_ordered_ff;
   logic [8:0]        rsp_index_ff;
   logic              rsp_range_ff;
   logic              hit;

   // Even bits go to the low nibble, odd bits to the high nibble.
   function automatic logic [7:0] deinterleave(input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int k = 0; k < 4; k++) begin
         r[k]     = v[2 * k];
         r[4 + k] = v[2 * k + 1];
      end
      return r;
   endfunction

   assign clear_busy = clearing_ff;

   // Pixel coordinates, bounds and byte address of the current step.
   always_comb begin
      px        = seg_ff.vert ? seg_ff.x : seg_ff.x + step_ff;
      py        = seg_ff.vert ? seg_ff.y + step_ff : seg_ff.y;
      op_inside = ({1'b0, px} < 9'(COLUMNS)) && ({1'b0, py} < 9'(ROWS));
      lin       = LIN_W'(py[7:3]) * LIN_W'(COLUMNS) + LIN_W'(px);
      op_addr   = op_inside ? lin[ADDR_W-1:0] : '0;
      op_bit    = {py[1:0], py[2]};
      op_val    = seg_ff.use_pattern ? seg_ff.pattern[step_ff[2:0]] : seg_ff.value;
      op_final  = ({1'b0, step_ff} + 9'd1) >= {1'b0, seg_ff.count};
      op_last   = seg_ff.last && op_final;
   end

   // A command's last pixel waits until the result register is sure to be free.
   assign issue = seg_valid_ff && !clearing_ff &&
                  !(op_last && (rsp_valid_ff || (b_valid_ff && b_last_ff)));
   assign seg_pop = !seg_empty && !clearing_ff && (!seg_valid_ff || (issue && op_final));

   // Run sequencing.
   always_comb begin
      seg_in       = seg_ff;
      seg_valid_in = seg_valid_ff;
      step_in      = step_ff;
      if (seg_pop) begin
         seg_in       = seg_data;
         seg_valid_in = 1'b1;
         step_in      = 8'd0;
      end else if (issue && op_final) begin
         seg_valid_in = 1'b0;
      end else if (issue) begin
         step_in = step_ff + 8'd1;
      end
   end

   // Clearing pass: one frame store byte per cycle.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(STORE_SIZE - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Merge the pixel into the byte, taking the newest copy of that byte.
   always_comb begin
      base   = (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) ? fwd_data_ff : ram_rd;
      mask   = 8'd1 << b_bit_ff;
      merged = b_val_ff ? (base | mask) : (base & ~mask);
      ram_we = clearing_ff || (b_valid_ff && b_write_ff);
      ram_wa = clearing_ff ? clr_addr_ff : b_addr_ff;
      ram_wd = clearing_ff ? 8'd0 : merged;
      hit    = b_read_ff && b_inside_ff;
   end

   ifd_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (issue),
      .rd_addr (op_addr),
      .rd_data (ram_rd)
   );

   // Result word: set by the last pixel of a command, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_valid_ff && b_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_valid_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_valid_ff <= seg_valid_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         b_valid_ff   <= issue;
         fwd_valid_ff <= b_valid_ff && b_write_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      seg_ff      <= seg_in;
      step_ff     <= step_in;
      b_write_ff  <= op_inside && !seg_ff.is_read && (seg_ff.count != 8'd0);
      b_addr_ff   <= op_addr;
      b_bit_ff    <= op_bit;
      b_val_ff    <= op_val;
      b_read_ff   <= seg_ff.is_read;
      b_inside_ff <= op_inside;
      b_last_ff   <= op_last;
      b_index_ff  <= lin[8:0];
      fwd_addr_ff <= b_addr_ff;
      fwd_data_ff <= merged;
      if (b_valid_ff && b_last_ff) begin
         rsp_raw_ff     <= hit ? base : 8'd0;
         rsp_ordered_ff <= hit ? deinterleave(base) : 8'd0;
         rsp_index_ff   <= hit ? b_index_ff : 9'd0;
         rsp_range_ff   <= hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_byte     = rsp_raw_ff;
   assign rsp_ordered_byte = rsp_ordered_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_in_range     = rsp_range_ff;

endmodule

// ===== rtl/interleaved_framebuffer_draw.sv =====
// ----------------------------------------------------------------------------
// interleaved_framebuffer_draw
// Drawing engine for a monochrome frame store with interleaved pixel rows.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one command word per handshake: pixel clear or set,
// byte write, horizontal or vertical line, rectangle outline, or byte read.
// Every command returns exactly one word on the rsp channel; only a read
// carries data, all other commands return zeros once their pixels are drawn.
// After reset the frame store, COLUMNS*PAGES bytes (512 at the default size),
// is cleared one byte per cycle, and req_ready stays low until then.
// A command's response word turns valid once its runs have passed the front
// end, the run queue, the draw unit's pixel and write stages and the result
// register; a run of no pixels still takes one step. A worst-case rectangle
// walks 318 pixels. The draw unit walks one pixel per cycle, set by the
// single read-modify-write path into the frame store, while runs are queued.
// The front end accepts the next command while the draw unit still works,
// as long as the run queue has room. When the receiver stalls, the result
// waits in the output register and the draw unit holds the next command's
// final pixel until that word has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interleaved_framebuffer_draw import ifd_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_run_length,
   input  logic [7:0] req_pixel_bits,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_raw_byte,
   output logic [7:0] rsp_ordered_byte,
   output logic [8:0] rsp_byte_index,
   output logic       rsp_in_range
);

   logic    clear_busy;
   logic    seg_push, seg_full, seg_pop, seg_empty;
   seg_type seg_wr, seg_rd;

   // Front end: decode commands into pixel runs.
   ifd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .clear_busy     (clear_busy),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_x          (req_x),
      .req_y          (req_y),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_run_length (req_run_length),
      .req_pixel_bits (req_pixel_bits),
      .seg_push       (seg_push),
      .seg_data       (seg_wr),
      .seg_full       (seg_full)
   );

   // Run queue between front end and draw unit.
   ifd_seg_fifo #(
      .DEPTH (4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (seg_push),
      .push_data (seg_wr),
      .full      (seg_full),
      .pop       (seg_pop),
      .pop_data  (seg_rd),
      .empty     (seg_empty)
   );

   // Draw unit with the frame store.
   ifd_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .clear_busy       (clear_busy),
      .seg_empty        (seg_empty),
      .seg_data         (seg_rd),
      .seg_pop          (seg_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_raw_byte     (rsp_raw_byte),
      .rsp_ordered_byte (rsp_ordered_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_in_range     (rsp_in_range)
   );

   // Queue discipline and the clearing pass.
   `ASSERT_ALWAYS(a_queue_no_overflow, !(seg_push && seg_full), "run pushed into a full queue")
   `ASSERT_ALWAYS(a_queue_no_underflow, !(seg_pop && seg_empty), "run popped from an empty queue")
   `ASSERT_IMPLIES(a_no_accept_clearing, clear_busy, !req_ready, "ready while store is cleared")
   `ASSERT_NEXT(a_clear_stays_done, !clear_busy, !clear_busy, "clearing pass restarted")

endmodule

// ===== test/ifd_draw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_draw_checker
// Watches both channels of the drawing engine and keeps its own copy of the
// frame store. Every accepted command word is applied to that copy, and the
// response word it must produce is queued. Every accepted response word is
// compared, field by field, against the oldest queued one.
// ----------------------------------------------------------------------------
module ifd_draw_checker import ifd_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_run_length,
   input  logic [7:0] req_pixel_bits,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_raw_byte,
   input  logic [7:0] rsp_ordered_byte,
   input  logic [8:0] rsp_byte_index,
   input  logic       rsp_in_range,
   output int         fail_count,
   output int         words_due
);

   localparam int STORE_BYTES = COLUMNS * ((ROWS + 7) / 8);

   // One response word as the engine must return it.
   typedef struct packed {
      logic [7:0] raw;
      logic [7:0] ordered;
      logic [8:0] index;
      logic       in_range;
   } rsp_word_type;

   logic [7:0]   pixels [STORE_BYTES];
   rsp_word_type awaited_words [$];

   // Write one pixel; coordinates outside the frame leave the store alone.
   function automatic void plot(input logic [7:0] px, input logic [7:0] py,
                                input logic on);
      int idx;
      if (px >= COLUMNS || py >= ROWS) return;
      idx = COLUMNS * (py >> 3) + px;
      if (idx >= STORE_BYTES) return;
      // Rows 0..3 of a page sit on even bits, rows 4..7 on odd bits.
      pixels[idx][{py[1:0], py[2]}] = on;
   endfunction

   // Set a run of pixels along a row or down a column, clipped to the line limit.
   function automatic void draw_run(input logic [7:0] px, input logic [7:0] py,
                                    input logic [7:0] len, input logic vert);
      logic [7:0] cap;
      logic [7:0] n;
      cap = vert ? VLINE_LIMIT : HLINE_LIMIT;
      n = (len < cap) ? len : cap;
      for (int i = 0; i < n; i++) begin
         if (vert) begin
            plot(px, py + 8'(i), 1'b1);
         end else begin
            plot(px + 8'(i), py, 1'b1);
         end
      end
   endfunction

   // Gather even bits into the low nibble and odd bits into the high nibble.
   function automatic logic [7:0] unweave(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 4; k++) begin
         r[k]     = v[2 * k];
         r[4 + k] = v[2 * k + 1];
      end
      return r;
   endfunction

   // Apply one command to the frame copy and return the word it answers with.
   function automatic rsp_word_type run_command(input logic [2:0] act,
         input logic [7:0] x, input logic [7:0] y, input logic [7:0] xe,
         input logic [7:0] ye, input logic [7:0] len, input logic [7:0] bits);
      rsp_word_type word;
      logic [7:0]   w;
      logic [7:0]   h;
      int           idx;
      word = '0;
      case (action_type'(act))
         ACT_CLEAR: plot(x, y, 1'b0);
         ACT_SET:   plot(x, y, 1'b1);
         ACT_BYTE: begin
            for (int k = 0; k < 8; k++) plot(x, y + 8'(k), bits[k]);
         end
         ACT_HLINE: draw_run(x, y, len, 1'b0);
         ACT_VLINE: draw_run(x, y, len, 1'b1);
         ACT_RECT: begin
            // Width and height wrap modulo 256 before the line limits apply.
            w = xe - x + 8'd1;
            h = ye - y;
            draw_run(x, y, h, 1'b1);
            draw_run(xe, y, h, 1'b1);
            draw_run(x, y, w, 1'b0);
            draw_run(x, ye, w, 1'b0);
         end
         ACT_READ: begin
            if (x < COLUMNS && y < ROWS) begin
               idx = COLUMNS * (y >> 3) + x;
               word.raw      = (idx < STORE_BYTES) ? pixels[idx] : 8'd0;
               word.ordered  = unweave(word.raw);
               word.index    = 9'(idx);
               word.in_range = 1'b1;
            end
         end
         default: ;
      endcase
      return word;
   endfunction

   function automatic void check_field(input string name, input int want,
                                       input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Sample both channels at the rising edge; responses are checked before
   // the command accepted at the same edge is applied.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         foreach (pixels[i]) pixels[i] = '0;
         awaited_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_words.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %0h %0h %0h %0h",
                        $time, rsp_raw_byte, rsp_ordered_byte, rsp_byte_index,
                        rsp_in_range);
               fail_count++;
            end else begin
               want = awaited_words.pop_front();
               check_field("raw_byte", want.raw, rsp_raw_byte);
               check_field("ordered_byte", want.ordered, rsp_ordered_byte);
               check_field("byte_index", want.index, rsp_byte_index);
               check_field("in_range", want.in_range, rsp_in_range);
            end
         end
         if (req_valid && req_ready) begin
            awaited_words.push_back(run_command(req_action, req_x, req_y, req_x_end,
                                                req_y_end, req_run_length,
                                                req_pixel_bits));
         end
      end
      words_due = awaited_words.size();
   end

endmodule

// ===== test/tb_interleaved_framebuffer_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interleaved_framebuffer_draw
// Drives command words into the drawing engine and lets the checker compare
// every response word. A directed opening covers the frame edges, coordinate
// wrap, line limits, rectangle corner cases and out-of-range reads; random
// drawing and reading follows under three patterns of idling on both sides.
// ----------------------------------------------------------------------------
module tb_interleaved_framebuffer_draw;
   import ifd_pkg::*;

   // The command field has one spare code that must do nothing.
   localparam logic [2:0] ACT_SPARE = 3'd7;
   localparam int RANDOM_WORDS = 1400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_action = '0;
   logic [7:0] req_x = '0;
   logic [7:0] req_y = '0;
   logic [7:0] req_x_end = '0;
   logic [7:0] req_y_end = '0;
   logic [7:0] req_run_length = '0;
   logic [7:0] req_pixel_bits = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_raw_byte;
   logic [7:0] rsp_ordered_byte;
   logic [8:0] rsp_byte_index;
   logic       rsp_in_range;
   int         fail_count;
   int         words_due;
   int         send_idle_pct = 37;
   int         recv_idle_pct = 87;

   interleaved_framebuffer_draw dut (.*);

   ifd_draw_checker checker_inst (.*);

   always #5 clock = ~clock;

   // The receiver stalls at random, decided once per cycle.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one command word, after random idle cycles, and wait until taken.
   task automatic send_word(input logic [2:0] act, input logic [7:0] x,
                            input logic [7:0] y, input logic [7:0] xe,
                            input logic [7:0] ye, input logic [7:0] len,
                            input logic [7:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_x          <= x;
      req_y          <= y;
      req_x_end      <= xe;
      req_y_end      <= ye;
      req_run_length <= len;
      req_pixel_bits <= bits;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Mostly in-frame drawing mixed with reads, with some noise words.
   task automatic send_random_word();
      int         pick;
      logic [2:0] act;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] xe;
      logic [7:0] ye;
      logic [7:0] len;
      logic [7:0] bits;
      pick = $urandom_range(99);
      x    = ($urandom_range(99) < 85) ? 8'($urandom_range(127)) : 8'($urandom);
      y    = ($urandom_range(99) < 85) ? 8'($urandom_range(31)) : 8'($urandom);
      len  = ($urandom_range(99) < 70) ? 8'($urandom_range(40)) : 8'($urandom);
      xe   = 8'($urandom);
      ye   = 8'($urandom);
      bits = 8'($urandom);
      if (pick < 30) begin
         act = ACT_READ;
      end else if (pick < 45) begin
         act = ACT_SET;
      end else if (pick < 53) begin
         act = ACT_CLEAR;
      end else if (pick < 65) begin
         act = ACT_BYTE;
      end else if (pick < 77) begin
         act = ACT_HLINE;
      end else if (pick < 87) begin
         act = ACT_VLINE;
      end else if (pick < 95) begin
         act = ACT_RECT;
      end else begin
         act = 3'($urandom);
         x   = 8'($urandom);
         y   = 8'($urandom);
      end
      // Most rectangles stay small; the rest keep fully random corners.
      if (act == ACT_RECT && $urandom_range(99) < 80) begin
         xe = x + 8'($urandom_range(40));
         ye = y + 8'($urandom_range(12));
      end
      send_word(act, x, y, xe, ye, len, bits);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Frame corners, pixels just off the frame, and reads of a fresh store.
      send_word(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_SET,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255);
      send_word(ACT_SET,   8'd127, 8'd31,  8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_SET,   8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_SET,   8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_SET,   8'd0,   8'd32,  8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_READ,  8'd127, 8'd31,  8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      // Byte writes across a page boundary and past row 255.
      send_word(ACT_BYTE,  8'd5,   8'd4,   8'd0,   8'd0,   8'd0,   8'hA5);
      send_word(ACT_BYTE,  8'd10,  8'd252, 8'd0,   8'd0,   8'd0,   8'hFF);
      // Lines beyond their limits, wrapping lines and an empty line.
      send_word(ACT_HLINE, 8'd0,   8'd16,  8'd0,   8'd0,   8'd255, 8'd0);
      send_word(ACT_HLINE, 8'd250, 8'd17,  8'd0,   8'd0,   8'd20,  8'd0);
      send_word(ACT_VLINE, 8'd3,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0);
      send_word(ACT_VLINE, 8'd7,   8'd250, 8'd0,   8'd0,   8'd10,  8'd0);
      send_word(ACT_HLINE, 8'd60,  8'd20,  8'd0,   8'd0,   8'd0,   8'd0);
      // A rectangle whose width wraps, and one with zero height.
      send_word(ACT_RECT,  8'd20,  8'd2,   8'd10,  8'd9,   8'd0,   8'd0);
      send_word(ACT_RECT,  8'd40,  8'd5,   8'd40,  8'd5,   8'd0,   8'd0);
      send_word(ACT_SPARE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      // Read back what was drawn, then two reads outside the frame.
      send_word(ACT_READ,  8'd5,   8'd8,   8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_READ,  8'd10,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_READ,  8'd126, 8'd16,  8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_READ,  8'd40,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_READ,  8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_word(ACT_READ,  8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0);

      // Three random phases; before each the sender holds off until drained.
      for (int phase = 0; phase < 3; phase++) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while (words_due != 0) @(negedge clock);
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 87 : 0;
         recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 37 : 0;
         for (int n = 0; n < RANDOM_WORDS / 3; n++) send_random_word();
      end
      req_valid <= 1'b0;

      // Drain, then watch a little longer for stray response words.
      while (words_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_interleaved_framebuffer_draw passed");
      end else begin
         $display("tb_interleaved_framebuffer_draw failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #40_000_000;
      $display("tb_interleaved_framebuffer_draw failed");
      $finish;
   end

endmodule
